// ===== rtl/frustum_plane_extractor_unit_assert.svh =====
// assertion macros for the frustum plane extractor checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef FRUSTUM_PLANE_EXTRACTOR_UNIT_ASSERT_SVH
`define FRUSTUM_PLANE_EXTRACTOR_UNIT_ASSERT_SVH

// clocked check, muted while reset is asserted
`define FPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define FPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/fpe_pkg.sv =====
// shared types and constants of the frustum plane extractor
// no dependencies
package fpe_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int NORM_FRAC   = 30;
  localparam int PLANE_COUNT = 6;
  localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

  // component selectors inside one plane job
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;
  localparam logic [1:0] SEL_D = 2'd3;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } group_t;

  typedef struct packed {
    logic [2:0]         idx;
    logic signed [32:0] comp_a;
    logic signed [32:0] comp_b;
    logic signed [32:0] comp_c;
    logic signed [32:0] comp_d;
  } plane_job_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

endpackage

// ===== rtl/fpe_front.sv =====
// front part: matrix group store and plane job generation
// depends on fpe_pkg
module fpe_front import fpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        group_index_i,
  input  logic [31:0]       elem_x_i,
  input  logic [31:0]       elem_y_i,
  input  logic [31:0]       elem_z_i,
  input  logic [31:0]       elem_w_i,
  input  logic              finish_i,
  output plane_job_t        job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output logic              emitting_o
);

  group_t     grp_q [4];
  logic       emit_q;
  logic [2:0] k_q;
  group_t     gsel;
  group_t     g3;
  logic       odd;

  function automatic logic signed [32:0] combine(input logic [31:0] w3, input logic [31:0] wj,
                                                 input logic sub);
    logic signed [32:0] a3;
    logic signed [32:0] aj;
    a3 = {w3[31], w3};
    aj = {wj[31], wj};
    return sub ? a3 - aj : a3 + aj;
  endfunction

  assign gsel = grp_q[k_q[2:1]];
  assign g3   = grp_q[3];
  assign odd  = k_q[0];

  always_comb begin
    job_o.idx    = k_q;
    job_o.comp_a = combine(g3.x, gsel.x, odd);
    job_o.comp_b = combine(g3.y, gsel.y, odd);
    job_o.comp_c = combine(g3.z, gsel.z, odd);
    job_o.comp_d = combine(g3.w, gsel.w, odd);
  end

  assign job_valid_o = emit_q;
  assign emitting_o  = emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        grp_q[i] <= '0;
      end
      emit_q <= 1'b0;
      k_q    <= '0;
    end else begin
      if (accept_i) begin
        grp_q[group_index_i] <= '{x: elem_x_i, y: elem_y_i, z: elem_z_i, w: elem_w_i};
        if (finish_i) begin
          emit_q <= 1'b1;
          k_q    <= '0;
        end
      end else if (emit_q && job_ready_i) begin
        if (k_q == LAST_PLANE) begin
          emit_q <= 1'b0;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/fpe_queue.sv =====
// two entry job queue between front and back
// depends on fpe_pkg
module fpe_queue import fpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  plane_job_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output plane_job_t data_o,
  output logic       empty_o
);

  plane_job_t mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/fpe_back.sv =====
// back part: squared length, integer square root, four restoring divisions
// depends on fpe_pkg
module fpe_back import fpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  plane_job_t  job_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        busy_o,
  output logic        result_valid_o,
  output logic [2:0]  plane_index_o,
  output logic [31:0] normal_a_o,
  output logic [31:0] normal_b_o,
  output logic [31:0] normal_c_o,
  output logic [31:0] offset_d_o,
  output logic        zero_length_o,
  output logic        last_plane_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  st_q;
  plane_job_t  job_q;
  logic [5:0]  cnt_q;
  logic [1:0]  sel_q;
  logic [65:0] prod_q;
  logic [65:0] acc_q;
  logic [65:0] rad_q;
  logic [35:0] rem_q;
  logic [32:0] root_q;
  logic [63:0] num_q;
  logic [33:0] drem_q;
  logic [31:0] na_q, nb_q, nc_q, od_q;
  logic        zero_q;

  logic signed [32:0] comp_sel;
  logic [32:0] sq_src;
  logic [65:0] prod_d;
  logic [35:0] rem_n, trial, rem_d;
  logic [32:0] root_d;
  logic [33:0] drem_n, drem_d;
  logic [63:0] num_d;
  logic        dneg;
  logic [31:0] qres;

  function automatic logic signed [32:0] pick(input plane_job_t j, input logic [1:0] s);
    logic signed [32:0] r;
    case (s)
      SEL_A:   r = j.comp_a;
      SEL_B:   r = j.comp_b;
      SEL_C:   r = j.comp_c;
      default: r = j.comp_d;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] init_num(input plane_job_t j, input logic [1:0] s);
    logic [63:0] m;
    m = 64'(mag33(pick(j, s)));
    return (s == SEL_D) ? (m << FRAC_BITS) : (m << NORM_FRAC);
  endfunction

  // squaring source follows the cycle count
  assign sq_src = mag33(pick(job_q, cnt_q[1:0]));
  assign prod_d = 66'(sq_src) * 66'(sq_src);

  // one root digit per cycle
  always_comb begin
    rem_n = {rem_q[33:0], rad_q[65:64]};
    trial = {1'b0, root_q, 2'b01};
    if (rem_n >= trial) begin
      rem_d  = rem_n - trial;
      root_d = {root_q[31:0], 1'b1};
    end else begin
      rem_d  = rem_n;
      root_d = {root_q[31:0], 1'b0};
    end
  end

  // one quotient bit per cycle
  always_comb begin
    drem_n = {drem_q[32:0], num_q[63]};
    if (drem_n >= {1'b0, root_q}) begin
      drem_d = drem_n - {1'b0, root_q};
      num_d  = {num_q[62:0], 1'b1};
    end else begin
      drem_d = drem_n;
      num_d  = {num_q[62:0], 1'b0};
    end
  end

  assign comp_sel = pick(job_q, sel_q);
  assign dneg     = comp_sel[32];

  always_comb begin
    if (sel_q == SEL_D) begin
      if (!dneg) begin
        qres = (num_d > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_d[31:0];
      end else begin
        qres = (num_d > 64'h8000_0000) ? 32'h8000_0000 : 32'(-num_d[31:0]);
      end
    end else begin
      qres = dneg ? 32'(-num_d[31:0]) : num_d[31:0];
    end
  end

  assign pop_o          = (st_q == ST_IDLE) && !empty_i;
  assign busy_o         = (st_q != ST_IDLE);
  assign result_valid_o = (st_q == ST_OUT);
  assign plane_index_o  = job_q.idx;
  assign normal_a_o     = na_q;
  assign normal_b_o     = nb_q;
  assign normal_c_o     = nc_q;
  assign offset_d_o     = od_q;
  assign zero_length_o  = zero_q;
  assign last_plane_o   = (job_q.idx == LAST_PLANE);

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          job_q <= job_i;
          acc_q <= '0;
        end
      end
      ST_SQ: begin
        prod_q <= prod_d;
        if (cnt_q != 6'd0) acc_q <= acc_q + prod_q;
        if (cnt_q == 6'd3) begin
          rad_q  <= acc_q + prod_q;
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_ROOT: begin
        rad_q  <= {rad_q[63:0], 2'b00};
        rem_q  <= rem_d;
        root_q <= root_d;
        if (cnt_q == 6'd32) begin
          num_q  <= init_num(job_q, SEL_A);
          drem_q <= '0;
          zero_q <= (root_d == '0);
          na_q   <= '0;
          nb_q   <= '0;
          nc_q   <= '0;
          od_q   <= '0;
        end
      end
      ST_DIV: begin
        if (cnt_q == 6'd63) begin
          case (sel_q)
            SEL_A:   na_q <= qres;
            SEL_B:   nb_q <= qres;
            SEL_C:   nc_q <= qres;
            default: od_q <= qres;
          endcase
          num_q  <= init_num(job_q, sel_q + 2'd1);
          drem_q <= '0;
        end else begin
          drem_q <= drem_d;
          num_q  <= num_d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      sel_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (!empty_i) begin
            st_q  <= ST_SQ;
            cnt_q <= '0;
          end
        end
        ST_SQ: begin
          if (cnt_q == 6'd3) begin
            st_q  <= ST_ROOT;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_ROOT: begin
          if (cnt_q == 6'd32) begin
            cnt_q <= '0;
            sel_q <= SEL_A;
            st_q  <= (root_d == '0) ? ST_OUT : ST_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            if (sel_q == SEL_D) st_q <= ST_OUT;
            sel_q <= sel_q + 2'd1;
          end
        end
        ST_OUT: begin
          st_q <= ST_IDLE;
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/frustum_plane_extractor_unit.sv =====
// frustum plane extractor, built from fpe_pkg, fpe_front, fpe_queue and fpe_back
// an accepted item is written to the group store; after a finish transfer the six planes
// are strobed one after another, each going through pop, squaring, root, four divisions
// and output; zero-length planes skip the divisions
// throughput: one item per cycle with busy low; busy holds until the sixth plane is out
// results cannot be stalled; reset (rst_ni low, async) clears the store and idles control
module frustum_plane_extractor_unit import fpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  group_index_i,
  input  logic [31:0] elem_x_i,
  input  logic [31:0] elem_y_i,
  input  logic [31:0] elem_z_i,
  input  logic [31:0] elem_w_i,
  input  logic        finish_i,
  output logic        result_valid_o,
  output logic [2:0]  plane_index_o,
  output logic [31:0] normal_a_o,
  output logic [31:0] normal_b_o,
  output logic [31:0] normal_c_o,
  output logic [31:0] offset_d_o,
  output logic        zero_length_o,
  output logic        last_plane_o
);

  // item transfer
  logic       accept;
  // front to queue
  plane_job_t front_job;
  logic       front_valid;
  logic       q_full;
  logic       emitting;
  // queue to back
  plane_job_t q_job;
  logic       q_empty;
  logic       back_pop;
  logic       back_busy;

  assign accept = start && !busy;

  // busy covers job generation, queued jobs and the plane in flight
  assign busy = emitting || !q_empty || back_busy;

  fpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .group_index_i (group_index_i),
    .elem_x_i      (elem_x_i),
    .elem_y_i      (elem_y_i),
    .elem_z_i      (elem_z_i),
    .elem_w_i      (elem_w_i),
    .finish_i      (finish_i),
    .job_o         (front_job),
    .job_valid_o   (front_valid),
    .job_ready_i   (!q_full),
    .emitting_o    (emitting)
  );

  fpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .data_o  (q_job),
    .empty_o (q_empty)
  );

  fpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (q_job),
    .empty_i        (q_empty),
    .pop_o          (back_pop),
    .busy_o         (back_busy),
    .result_valid_o (result_valid_o),
    .plane_index_o  (plane_index_o),
    .normal_a_o     (normal_a_o),
    .normal_b_o     (normal_b_o),
    .normal_c_o     (normal_c_o),
    .offset_d_o     (offset_d_o),
    .zero_length_o  (zero_length_o),
    .last_plane_o   (last_plane_o)
  );

endmodule

// ===== rtl/fpe_checker.sv =====
// port level checks of the frustum plane extractor, bound to the top level
// depends on fpe_pkg and frustum_plane_extractor_unit_assert.svh
`include "frustum_plane_extractor_unit_assert.svh"
module fpe_checker import fpe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        finish_i,
  input logic        result_valid_o,
  input logic [2:0]  plane_index_o,
  input logic [31:0] normal_a_o,
  input logic [31:0] normal_b_o,
  input logic [31:0] normal_c_o,
  input logic [31:0] offset_d_o,
  input logic        zero_length_o,
  input logic        last_plane_o
);

  logic last_ok;
  logic zero_ok;

  assign last_ok = (last_plane_o == (plane_index_o == LAST_PLANE));
  assign zero_ok = ({normal_a_o, normal_b_o, normal_c_o, offset_d_o} == '0);

  `FPE_ASSERT(a_finish_busy, start && !busy && finish_i |=> busy, "finish without busy")
  `FPE_ASSERT(a_result_busy, result_valid_o |-> busy, "result outside a run")
  `FPE_ASSERT(a_last_idx, result_valid_o |-> last_ok, "last flag wrong")
  `FPE_ASSERT(a_zero_out, result_valid_o && zero_length_o |-> zero_ok, "zero plane not zero")
  `FPE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !result_valid_o, "result in reset")

endmodule

bind frustum_plane_extractor_unit fpe_checker u_chk (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for frustum_plane_extractor_unit: matrix group loads
// and six-plane runs, checked against an internal plane predictor
// depends on fpe_pkg and the frustum_plane_extractor_unit rtl
`timescale 1ns / 100ps

module testbench;
  import fpe_pkg::*;

  // one matrix group load, as driven on the command ports
  typedef struct {
    logic [1:0]  grp;
    logic [31:0] x, y, z, w;
    logic        fin;
  } group_load_t;

  // one normalized plane, as seen on the result ports
  typedef struct {
    logic [2:0]  idx;
    logic [31:0] na, nb, nc, dd;
    logic        zl, lp;
  } plane_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_RUNS    = 73;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  group_index_i = '0;
  logic [31:0] elem_x_i = '0, elem_y_i = '0, elem_z_i = '0, elem_w_i = '0;
  logic        finish_i = 1'b0;
  logic        result_valid_o;
  logic [2:0]  plane_index_o;
  logic [31:0] normal_a_o, normal_b_o, normal_c_o, offset_d_o;
  logic        zero_length_o, last_plane_o;

  frustum_plane_extractor_unit dut (.*);

  // pending group loads, planes still owed by the block, predictor's matrix copy
  group_load_t load_queue[$];
  plane_t      plane_queue[$];
  logic [31:0] matrix_copy[16];

  group_load_t cur_load;
  int loads_sent = 0, frames_run = 0, planes_seen = 0;
  int zero_planes = 0, clipped_offsets = 0, errors = 0, quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // truncating division of v * 2^sh by len, sign kept
  function automatic longint scaled_quot(longint v, int sh, logic [34:0] len);
    longint unsigned num, q;
    num = (v < 0 ? -v : v) << sh;
    q = num / {29'b0, len};
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // store one group, and on finish work out the six planes it triggers
  task automatic predict_planes(group_load_t ld);
    longint comp[4];
    logic [67:0] sumsq;
    logic [34:0] len, cand;
    logic [69:0] sq;
    longint dq;
    plane_t p;
    matrix_copy[ld.grp]      = ld.x;
    matrix_copy[4 + ld.grp]  = ld.y;
    matrix_copy[8 + ld.grp]  = ld.z;
    matrix_copy[12 + ld.grp] = ld.w;
    if (!ld.fin) return;
    frames_run++;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      // even planes: group j plus group 3, odd planes: group 3 minus group j
      for (int i = 0; i < 4; i++) begin
        longint wj, w3;
        wj = longint'($signed(matrix_copy[4 * i + k / 2]));
        w3 = longint'($signed(matrix_copy[4 * i + 3]));
        comp[i] = (k % 2 == 1) ? w3 - wj : w3 + wj;
      end
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
        logic [33:0] m;
        m = 34'(comp[i] < 0 ? -comp[i] : comp[i]);
        sumsq += {34'b0, m} * {34'b0, m};
      end
      // bitwise floor square root
      len = '0;
      for (int b = 34; b >= 0; b--) begin
        cand = len | (35'd1 << b);
        sq = {35'b0, cand} * {35'b0, cand};
        if (sq <= {2'b0, sumsq}) len = cand;
      end
      p.idx = 3'(k);
      p.lp  = (k == PLANE_COUNT - 1);
      if (len == 0) begin
        p.na = '0; p.nb = '0; p.nc = '0; p.dd = '0; p.zl = 1'b1;
      end else begin
        p.na = 32'(scaled_quot(comp[0], NORM_FRAC, len));
        p.nb = 32'(scaled_quot(comp[1], NORM_FRAC, len));
        p.nc = 32'(scaled_quot(comp[2], NORM_FRAC, len));
        dq = scaled_quot(comp[3], FRAC_BITS, len);
        // offset saturates to the 32-bit signed range
        if (dq > 64'sd2147483647) dq = 64'sd2147483647;
        if (dq < -64'sd2147483648) dq = -64'sd2147483648;
        p.dd = 32'(dq);
        p.zl = 1'b0;
      end
      plane_queue.push_back(p);
    end
  endtask

  // driver: one command in flight, start held until accepted, with random idle gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        predict_planes(cur_load);
        loads_sent++;
        go = 1'b0;
      end
      // no idling in a stretch of loads in the middle of the run
      if (!go && load_queue.size() > 0 &&
          ((loads_sent >= 110 && loads_sent < 170) || $urandom_range(99) >= 38)) begin
        cur_load = load_queue.pop_front();
        group_index_i <= cur_load.grp;
        elem_x_i      <= cur_load.x;
        elem_y_i      <= cur_load.y;
        elem_z_i      <= cur_load.z;
        elem_w_i      <= cur_load.w;
        finish_i      <= cur_load.fin;
        go = 1'b1;
      end
      start <= go;
    end
  end

  // monitor: each strobed plane against the oldest predicted one
  always @(posedge clk_i) begin
    plane_t e;
    if (rst_ni && result_valid_o) begin
      planes_seen++;
      if (plane_queue.size() == 0) begin
        $error("plane %0d arrived with none predicted", plane_index_o);
        errors++;
      end else begin
        e = plane_queue.pop_front();
        if (e.zl) zero_planes++;
        if (!e.zl && (e.dd == 32'h7fffffff || e.dd == 32'h80000000)) clipped_offsets++;
        if (plane_index_o !== e.idx) begin
          $error("plane_index: expected %0d, got %0d", e.idx, plane_index_o); errors++;
        end
        if (normal_a_o !== e.na) begin
          $error("normal_a: expected %h, got %h", e.na, normal_a_o); errors++;
        end
        if (normal_b_o !== e.nb) begin
          $error("normal_b: expected %h, got %h", e.nb, normal_b_o); errors++;
        end
        if (normal_c_o !== e.nc) begin
          $error("normal_c: expected %h, got %h", e.nc, normal_c_o); errors++;
        end
        if (offset_d_o !== e.dd) begin
          $error("offset_d: expected %h, got %h", e.dd, offset_d_o); errors++;
        end
        if (zero_length_o !== e.zl) begin
          $error("zero_length: expected %b, got %b", e.zl, zero_length_o); errors++;
        end
        if (last_plane_o !== e.lp) begin
          $error("last_plane: expected %b, got %b", e.lp, last_plane_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles with neither a command nor a plane transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("** frustum_plane_extractor_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // matrix word of a random magnitude class, so small and huge values both show up
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(255)) - 128);
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      4: return 32'h0;
      default: return 32'($signed($urandom_range(16777215)) - 8388608);
    endcase
  endfunction

  function automatic group_load_t mk_load(logic [1:0] g, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [31:0] w, logic f);
    group_load_t ld;
    ld.grp = g; ld.x = x; ld.y = y; ld.z = z; ld.w = w; ld.fin = f;
    return ld;
  endfunction

  initial begin
    int order[4];
    for (int i = 0; i < 16; i++) matrix_copy[i] = '0;

    // finish straight after reset: store holds only one group, rest zero
    load_queue.push_back(mk_load(2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1));
    // all-zero matrix: every plane has zero length
    for (int g = 0; g < 4; g++) load_queue.push_back(mk_load(2'(g), 0, 0, 0, 0, g == 3));
    // identity, a plain symmetric frustum
    for (int g = 0; g < 4; g++)
      load_queue.push_back(mk_load(2'(g), g == 0 ? 32'h10000 : 0, g == 1 ? 32'h10000 : 0,
                                   g == 2 ? 32'h10000 : 0, g == 3 ? 32'h10000 : 0, g == 3));
    // every word at the positive then the negative extreme
    for (int g = 0; g < 4; g++)
      load_queue.push_back(mk_load(2'(g), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h7fffffff, g == 3));
    for (int g = 0; g < 4; g++)
      load_queue.push_back(mk_load(2'(g), 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, g == 3));
    // tiny normal, huge distance: offset saturates both ways
    load_queue.push_back(mk_load(2'd3, 32'h1, 32'h0, 32'h0, 32'h7fffffff, 1'b0));
    load_queue.push_back(mk_load(2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    load_queue.push_back(mk_load(2'd3, 32'hffffffff, 32'h0, 32'h0, 32'h80000000, 1'b1));

    // random frames: four groups in shuffled order, finish on the last,
    // with some broken runs (early finish or a stray group)
    for (int r = 0; r < RANDOM_RUNS; r++) begin
      for (int i = 0; i < 4; i++) order[i] = i;
      order.shuffle();
      if ($urandom_range(9) < 2) begin
        load_queue.push_back(mk_load(2'($urandom_range(3)), rand_word(), rand_word(),
                                     rand_word(), rand_word(), 1'($urandom_range(1))));
      end else begin
        for (int i = 0; i < 4; i++)
          load_queue.push_back(mk_load(2'(order[i]), rand_word(), rand_word(), rand_word(),
                                       rand_word(), i == 3));
      end
    end
    load_queue.push_back(mk_load(2'($urandom_range(3)), rand_word(), rand_word(),
                                 rand_word(), rand_word(), 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (load_queue.size() == 0 && !start && plane_queue.size() == 0);
    repeat (20) @(posedge clk_i);
    if (plane_queue.size() != 0) begin
      $error("%0d planes never arrived", plane_queue.size());
      errors++;
    end
    $display("covered %0d group loads, %0d frames, %0d planes checked",
             loads_sent, frames_run, planes_seen);
    $display("  of those %0d zero-length planes and %0d clipped offsets",
             zero_planes, clipped_offsets);
    if (errors == 0) begin
      $display("** frustum_plane_extractor_unit: PASSED **");
    end else begin
      $display("** frustum_plane_extractor_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== frustum_plane_extractor_unit.f =====
+incdir+rtl
rtl/fpe_pkg.sv
rtl/fpe_front.sv
rtl/fpe_queue.sv
rtl/fpe_back.sv
rtl/frustum_plane_extractor_unit.sv
rtl/fpe_checker.sv
tb/sv/testbench.sv
